[rtl/cbor_item_head_encoder_defines.svh]
// Assertion macros shared by the encoder RTL.
// Checks are compiled only when SYNTHESIS is not defined.
`ifndef CBOR_ITEM_HEAD_ENCODER_DEFINES_SVH
`define CBOR_ITEM_HEAD_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define CIE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbor encoder assertion failed");
`define CIE_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cbor encoder forbidden condition");
`else
`define CIE_ASSERT(label, clk, rst_n, prop)
`define CIE_NEVER(label, clk, rst_n, expr)
`endif

`endif

[rtl/cbor_enc_pkg.sv]
`timescale 1ns / 1ps
package cbor_enc_pkg;

    // Position and length counters
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] BUFFER_LIMIT = 17'h10000;
    localparam logic [POS_W-1:0] BUFFER_SIZE_RESET = 17'h10000;

    // Argument bytes after the head byte: 0, 1, 2, 4 or 8
    localparam int FOLLOW_W = 4;
    localparam logic [FOLLOW_W-1:0] MAX_FOLLOW = 4'd8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_HEAD    = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // Major types with special handling
    localparam logic [2:0] MT_NEG_INT = 3'd1;
    localparam logic [2:0] MT_BYTES   = 3'd2;
    localparam logic [2:0] MT_TEXT    = 3'd3;

    // Additional info codes
    localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
    localparam logic [4:0] AI_TWO_BYTES  = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTES = 5'd26;
    localparam logic [4:0] AI_EIGHT_BYTES = 5'd27;
    localparam logic [4:0] AI_INDEFINITE = 5'd31;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  major;
        logic [63:0] argument;
        logic        indefinite;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // One classified item: the first beat plus the argument bytes to follow
    typedef struct packed {
        logic [7:0]          first_byte;
        logic                has_byte;
        logic [1:0]          status;
        logic [FOLLOW_W-1:0] follow;
        logic [63:0]         arg;
    } t_cmd;

endpackage

[rtl/cbor_enc_front.sv]
`timescale 1ns / 1ps
`include "cbor_item_head_encoder_defines.svh"
module cbor_enc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cbor_enc_pkg::POS_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  cbor_enc_pkg::t_in_item         i_item,
    output cbor_enc_pkg::t_cmd             o_cmd
);

    logic [cbor_enc_pkg::POS_W-1:0] r_buffer_size;
    logic [cbor_enc_pkg::POS_W-1:0] r_wp, n_wp;
    logic [cbor_enc_pkg::POS_W-1:0] r_pr, n_pr;

    logic [63:0]                         arg_eff;
    logic [4:0]                          info;
    logic [cbor_enc_pkg::FOLLOW_W-1:0]   follow;
    logic                                is_str;
    logic                                too_long;
    logic [cbor_enc_pkg::POS_W-1:0]      payload;
    logic [cbor_enc_pkg::POS_W-1:0]      size;
    logic [cbor_enc_pkg::POS_W-1:0]      space;
    logic [cbor_enc_pkg::POS_W:0]        total;
    logic                                overrun;

    always_comb begin
        arg_eff = (i_item.major == cbor_enc_pkg::MT_NEG_INT) ?
                  ~i_item.argument : i_item.argument;

        // Shortest additional info
        if (i_item.indefinite) begin
            info   = cbor_enc_pkg::AI_INDEFINITE;
            follow = '0;
        end else if (|arg_eff[63:32]) begin
            info   = cbor_enc_pkg::AI_EIGHT_BYTES;
            follow = 4'd8;
        end else if (|arg_eff[31:16]) begin
            info   = cbor_enc_pkg::AI_FOUR_BYTES;
            follow = 4'd4;
        end else if (|arg_eff[15:8]) begin
            info   = cbor_enc_pkg::AI_TWO_BYTES;
            follow = 4'd2;
        end else if (arg_eff[7:0] >= 8'd24) begin
            info   = cbor_enc_pkg::AI_ONE_BYTE;
            follow = 4'd1;
        end else begin
            info   = arg_eff[4:0];
            follow = '0;
        end

        is_str   = !i_item.indefinite &&
                   (i_item.major == cbor_enc_pkg::MT_BYTES ||
                    i_item.major == cbor_enc_pkg::MT_TEXT);
        too_long = is_str && (|arg_eff[63:cbor_enc_pkg::POS_W]);
        payload  = is_str ? arg_eff[cbor_enc_pkg::POS_W-1:0] : '0;

        size  = (r_buffer_size > cbor_enc_pkg::BUFFER_LIMIT) ?
                cbor_enc_pkg::BUFFER_LIMIT : r_buffer_size;
        space = (r_wp < size) ? size - r_wp : '0;
        total = {1'b0, payload} + (cbor_enc_pkg::POS_W+1)'(follow)
                + (cbor_enc_pkg::POS_W+1)'(1);
        overrun = too_long || (total > {1'b0, space});

        n_wp  = r_wp;
        n_pr  = r_pr;
        o_cmd = '0;
        o_cmd.status = cbor_enc_pkg::ST_OK;
        case (i_item.op)
            cbor_enc_pkg::OP_HEAD: begin
                if (overrun) begin
                    o_cmd.status = cbor_enc_pkg::ST_OVERRUN;
                end else begin
                    o_cmd.first_byte = {i_item.major, info};
                    o_cmd.has_byte   = 1'b1;
                    o_cmd.follow     = follow;
                    o_cmd.arg        = arg_eff;
                    n_wp = r_wp + total[cbor_enc_pkg::POS_W-1:0];
                    n_pr = payload;
                end
            end
            cbor_enc_pkg::OP_PAYLOAD: begin
                if (r_pr != '0) begin
                    o_cmd.first_byte = i_item.payload_byte;
                    o_cmd.has_byte   = 1'b1;
                    n_pr = r_pr - 1'b1;
                end else begin
                    o_cmd.status = cbor_enc_pkg::ST_DROPPED;
                end
            end
            cbor_enc_pkg::OP_RESTART: begin
                n_wp = '0;
                n_pr = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= cbor_enc_pkg::BUFFER_SIZE_RESET;
            r_wp          <= '0;
            r_pr          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_buffer_size <= i_cfg_data;
            end
            if (i_accept) begin
                r_wp <= n_wp;
                r_pr <= n_pr;
            end
        end
    end

    `CIE_NEVER(a_wp_in_range, i_clk, i_rst_n, r_wp > cbor_enc_pkg::BUFFER_LIMIT)
    `CIE_NEVER(a_pr_reserved, i_clk, i_rst_n, r_pr > r_wp)

endmodule

[rtl/cbor_enc_queue.sv]
`timescale 1ns / 1ps
`include "cbor_item_head_encoder_defines.svh"
module cbor_enc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cbor_enc_pkg::t_cmd i_push_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output cbor_enc_pkg::t_cmd o_pop_data
);

    cbor_enc_pkg::t_cmd r_mem [cbor_enc_pkg::QUEUE_DEPTH];
    logic [cbor_enc_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [cbor_enc_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [cbor_enc_pkg::QUEUE_PTR_W:0]   r_count;

    assign o_full     = (r_count == (cbor_enc_pkg::QUEUE_PTR_W+1)'(cbor_enc_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CIE_NEVER(a_count_bound, i_clk, i_rst_n, r_count > (cbor_enc_pkg::QUEUE_PTR_W+1)'(cbor_enc_pkg::QUEUE_DEPTH))
    `CIE_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> r_count != '0)

endmodule

[rtl/cbor_enc_back.sv]
`timescale 1ns / 1ps
`include "cbor_item_head_encoder_defines.svh"
module cbor_enc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  cbor_enc_pkg::t_cmd        i_q_data,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output cbor_enc_pkg::t_out_item   o_item
);

    logic                              r_out_valid, n_out_valid;
    cbor_enc_pkg::t_out_item           r_out, n_out;
    logic [cbor_enc_pkg::FOLLOW_W-1:0] r_cnt, n_cnt;
    logic [63:0]                       r_sh, n_sh;
    logic                              load;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign load    = !r_out_valid || i_ready;
    assign o_q_pop = load && (r_cnt == '0) && i_q_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_cnt       = r_cnt;
        n_sh        = r_sh;
        if (load) begin
            if (r_cnt != '0) begin
                // Shift out the next argument byte, MSB first
                n_out_valid     = 1'b1;
                n_out.out_byte  = r_sh[63:56];
                n_out.has_byte  = 1'b1;
                n_out.status    = cbor_enc_pkg::ST_OK;
                n_out.last      = (r_cnt == 4'd1);
                n_sh            = {r_sh[55:0], 8'h00};
                n_cnt           = r_cnt - 1'b1;
            end else if (i_q_valid) begin
                n_out_valid     = 1'b1;
                n_out.out_byte  = i_q_data.first_byte;
                n_out.has_byte  = i_q_data.has_byte;
                n_out.status    = i_q_data.status;
                n_out.last      = (i_q_data.follow == '0);
                n_cnt           = i_q_data.follow;
                case (i_q_data.follow)
                    4'd1:    n_sh = {i_q_data.arg[7:0], 56'h0};
                    4'd2:    n_sh = {i_q_data.arg[15:0], 48'h0};
                    4'd4:    n_sh = {i_q_data.arg[31:0], 32'h0};
                    default: n_sh = i_q_data.arg;
                endcase
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_out <= n_out;
        r_sh  <= n_sh;
    end

    `CIE_ASSERT(a_more_bytes_pending, i_clk, i_rst_n, (r_out_valid && !r_out.last) |-> r_cnt != '0)
    `CIE_NEVER(a_cnt_bound, i_clk, i_rst_n, r_cnt > cbor_enc_pkg::MAX_FOLLOW)

endmodule

[rtl/cbor_item_head_encoder.sv]
`timescale 1ns / 1ps
// CBOR item head encoder. Each input beat is a head, a string payload byte
// or a restart; each output beat is one byte slot with its status and a last
// flag closing the results of one input. A head produces 1 + N output beats,
// N being 0, 1, 2, 4 or 8 big-endian argument bytes; an overrun, payload
// byte, restart or unknown op produces one beat. The output runs at one beat
// per cycle while i_out_ready is high. The front classifies an input in the
// cycle it is accepted, updates the write position and pending payload count
// at once, and pushes one command into a 4-entry queue, so inputs are taken
// every cycle while the queue has room; the back serializes argument bytes
// through a shift register into the output register. An accepted input is
// registered in the queue and then in the output register. The buffer size
// register may be written at any idle time; sizes above 65536 are limited to
// 65536. o_cfg_ready is always high.
module cbor_item_head_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbor_enc_pkg::POS_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cbor_enc_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cbor_enc_pkg::t_out_item        o_out_item
);

    cbor_enc_pkg::t_cmd cmd;
    cbor_enc_pkg::t_cmd q_data;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               accept;

    // Take a beat whenever the queue has a free slot
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign accept      = i_in_valid && !q_full;

    cbor_enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_cmd       (cmd)
    );

    cbor_enc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_data (cmd),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_pop_data  (q_data)
    );

    cbor_enc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule

[bench/cbor_item_head_checker.sv]
`timescale 1ns / 1ps
module cbor_item_head_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cbor_enc_pkg::POS_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  cbor_enc_pkg::t_in_item         i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  cbor_enc_pkg::t_out_item        i_out_item,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_beats_checked,
    output int                             o_overruns,
    output int                             o_drops
);

    localparam int MAX_REPORTS = 10;

    // Encoder state as the bench sees it
    logic [cbor_enc_pkg::POS_W-1:0] size_reg;
    logic [cbor_enc_pkg::POS_W-1:0] wr_pos;
    logic [cbor_enc_pkg::POS_W-1:0] str_left;

    cbor_enc_pkg::t_out_item encoded_beats [$];

    int n_errors  = 0;
    int n_checked = 0;
    int n_overrun = 0;
    int n_dropped = 0;

    function automatic cbor_enc_pkg::t_out_item out_beat(input logic [7:0] b,
                                                         input logic has,
                                                         input logic [1:0] st,
                                                         input logic lst);
        cbor_enc_pkg::t_out_item r;
        r.out_byte = b;
        r.has_byte = has;
        r.status   = st;
        r.last     = lst;
        return r;
    endfunction

    // Shortest additional info for a definite argument
    function automatic logic [4:0] head_info(input logic [63:0] v);
        if (v[63:32] != 32'd0) return cbor_enc_pkg::AI_EIGHT_BYTES;
        if (v[63:16] != 48'd0) return cbor_enc_pkg::AI_FOUR_BYTES;
        if (v[63:8] != 56'd0) return cbor_enc_pkg::AI_TWO_BYTES;
        if (v >= 64'd24) return cbor_enc_pkg::AI_ONE_BYTE;
        return v[4:0];
    endfunction

    task automatic encode_item(input cbor_enc_pkg::t_in_item it);
        logic [63:0] arg;
        logic [63:0] str_len;
        logic [63:0] lim;
        logic [63:0] room;
        logic [63:0] need;
        logic [4:0]  info;
        int          n_follow;
        int          i;
        case (it.op)
            cbor_enc_pkg::OP_HEAD: begin
                lim  = (size_reg < cbor_enc_pkg::BUFFER_LIMIT) ?
                       64'(size_reg) : 64'(cbor_enc_pkg::BUFFER_LIMIT);
                room = (64'(wr_pos) < lim) ? lim - 64'(wr_pos) : 64'd0;
                arg  = (it.major == cbor_enc_pkg::MT_NEG_INT) ? ~it.argument : it.argument;
                str_len = 64'd0;
                if (it.indefinite) begin
                    info     = cbor_enc_pkg::AI_INDEFINITE;
                    n_follow = 0;
                end else begin
                    info     = head_info(arg);
                    n_follow = (info < cbor_enc_pkg::AI_ONE_BYTE) ?
                               0 : (1 << (info - cbor_enc_pkg::AI_ONE_BYTE));
                    if (it.major == cbor_enc_pkg::MT_BYTES ||
                        it.major == cbor_enc_pkg::MT_TEXT)
                        str_len = arg;
                end
                need = 64'(1 + n_follow);
                if (str_len > room || need + str_len > room) begin
                    encoded_beats.push_back(out_beat(8'd0, 1'b0, cbor_enc_pkg::ST_OVERRUN,
                                                     1'b1));
                    n_overrun++;
                end else begin
                    encoded_beats.push_back(out_beat({it.major, info}, 1'b1,
                                                     cbor_enc_pkg::ST_OK, n_follow == 0));
                    for (i = 0; i < n_follow; i++)
                        encoded_beats.push_back(out_beat(8'(arg >> (8 * (n_follow - 1 - i))),
                                                         1'b1, cbor_enc_pkg::ST_OK,
                                                         i + 1 == n_follow));
                    wr_pos   = cbor_enc_pkg::POS_W'(64'(wr_pos) + need + str_len);
                    str_left = str_len[cbor_enc_pkg::POS_W-1:0];
                end
            end
            cbor_enc_pkg::OP_PAYLOAD: begin
                if (str_left != '0) begin
                    str_left = str_left - 1'b1;
                    encoded_beats.push_back(out_beat(it.payload_byte, 1'b1,
                                                     cbor_enc_pkg::ST_OK, 1'b1));
                end else begin
                    encoded_beats.push_back(out_beat(8'd0, 1'b0, cbor_enc_pkg::ST_DROPPED,
                                                     1'b1));
                    n_dropped++;
                end
            end
            cbor_enc_pkg::OP_RESTART: begin
                wr_pos   = '0;
                str_left = '0;
                encoded_beats.push_back(out_beat(8'd0, 1'b0, cbor_enc_pkg::ST_OK, 1'b1));
            end
            default: begin
                encoded_beats.push_back(out_beat(8'd0, 1'b0, cbor_enc_pkg::ST_OK, 1'b1));
            end
        endcase
    endtask

    task automatic check_beat(input cbor_enc_pkg::t_out_item got);
        cbor_enc_pkg::t_out_item want;
        if (encoded_beats.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: unexpected output beat: byte %h has %b status %0d last %b",
                         $time, got.out_byte, got.has_byte, got.status, got.last);
        end else begin
            want = encoded_beats.pop_front();
            n_checked++;
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.status !== want.status || got.last !== want.last) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: beat mismatch: expected byte %h has %b status %0d last %b, %s",
                             $time, want.out_byte, want.has_byte, want.status, want.last,
                             $sformatf("got byte %h has %b status %0d last %b",
                                       got.out_byte, got.has_byte, got.status, got.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = cbor_enc_pkg::BUFFER_SIZE_RESET;
            wr_pos   = '0;
            str_left = '0;
            encoded_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                size_reg = i_cfg_data;
            if (i_in_valid && i_in_ready)
                encode_item(i_in_item);
            if (i_out_valid && i_out_ready)
                check_beat(i_out_item);
        end
        o_fail_count    <= n_errors;
        o_pending       <= encoded_beats.size();
        o_beats_checked <= n_checked;
        o_overruns      <= n_overrun;
        o_drops         <= n_dropped;
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    // Codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    // Each phase runs past its quota by the tail of its last string
    localparam int NUM_PHASES   = 9;
    localparam int RANDOM_ITEMS = 280;
    localparam int CYCLE_LIMIT  = 300000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cbor_enc_pkg::POS_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    cbor_enc_pkg::t_in_item         in_item   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    cbor_enc_pkg::t_out_item        out_item;

    int fail_count;
    int pending;
    int beats_checked;
    int overrun_count;
    int drop_count;

    int cycle_count = 0;
    int items_sent  = 0;
    int size_writes = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cbor_item_head_encoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    cbor_item_head_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked),
        .o_overruns      (overrun_count),
        .o_drops         (drop_count)
    );

    // Receiver: bits 9:8 of the cycle count pick the stall pattern. Mode 0 never
    // stalls, mode 1 is a coin toss, mode 2 takes one beat in four and mode 3
    // stalls now and then.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (cycle_count[1:0] == 2'b00);
            default: out_ready <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Hard stop in case the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // Every field random, so bits the op ignores still toggle
    function automatic cbor_enc_pkg::t_in_item rand_fields();
        cbor_enc_pkg::t_in_item it;
        it.op           = 2'($urandom_range(0, 3));
        it.major        = 3'($urandom_range(0, 7));
        it.argument     = {$urandom, $urandom};
        it.indefinite   = 1'($urandom_range(0, 1));
        it.payload_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic cbor_enc_pkg::t_in_item head(input logic [2:0] mt,
                                                    input logic [63:0] arg,
                                                    input logic indef);
        cbor_enc_pkg::t_in_item it;
        it            = rand_fields();
        it.op         = cbor_enc_pkg::OP_HEAD;
        it.major      = mt;
        it.argument   = arg;
        it.indefinite = indef;
        return it;
    endfunction

    function automatic cbor_enc_pkg::t_in_item pay(input logic [7:0] b);
        cbor_enc_pkg::t_in_item it;
        it              = rand_fields();
        it.op           = cbor_enc_pkg::OP_PAYLOAD;
        it.payload_byte = b;
        return it;
    endfunction

    function automatic cbor_enc_pkg::t_in_item ctl(input logic [1:0] op);
        cbor_enc_pkg::t_in_item it;
        it    = rand_fields();
        it.op = op;
        return it;
    endfunction

    // Argument spread over the five encoding lengths
    function automatic logic [63:0] rand_arg();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = v % 64'd24;
            1: v = 64'd24 + v % 64'd232;
            2: v = 64'd256 + v % 64'd65280;
            3: v = 64'h1_0000 + v % (64'h1_0000_0000 - 64'h1_0000);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [cbor_enc_pkg::POS_W-1:0] phase_size(input int p);
        case (p)
            0:       return 17'd40;
            1:       return 17'd0;
            2:       return 17'd1;
            3:       return 17'h1FFFF;
            4:       return 17'd300;
            5:       return 17'd12;
            6:       return 17'd65535;
            7:       return 17'd100;
            default: return 17'h10000;
        endcase
    endfunction

    // Send one input beat. Between bursts, while gaps_on is set, drop valid for a random gap first.
    task automatic send_item(input cbor_enc_pkg::t_in_item it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every expected beat has come back. The first
    // edge lets the checker's count catch up with the last accepted beat.
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_size(input logic [cbor_enc_pkg::POS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    // A string head followed by its payload. Now and then the payload runs
    // long (tail dropped) or is cut short by the next item.
    task automatic send_string();
        logic [2:0] mt;
        int         len;
        int         n;
        int         k;
        int         tweak;
        mt  = $urandom_range(0, 1) ? cbor_enc_pkg::MT_TEXT : cbor_enc_pkg::MT_BYTES;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        send_item(head(mt, 64'(len), 1'b0));
        n     = len;
        tweak = $urandom_range(0, 9);
        if (tweak == 0)
            n = len + $urandom_range(1, 2);
        else if (tweak == 1 && len > 0)
            n = $urandom_range(0, len - 1);
        for (k = 0; k < n; k++)
            send_item(pay(8'($urandom_range(0, 255))));
    endtask

    task automatic send_plain_head();
        logic [2:0]  mt;
        logic [63:0] arg;
        logic        indef;
        mt    = 3'($urandom_range(0, 7));
        arg   = rand_arg();
        indef = ($urandom_range(0, 9) == 0);
        // For negative integers, aim at small encoded values half the time
        if (mt == cbor_enc_pkg::MT_NEG_INT && $urandom_range(0, 1))
            arg = ~arg;
        send_item(head(mt, arg, indef));
    endtask

    task automatic run_random(input int quota);
        int start;
        int sel;
        start = items_sent;
        while (items_sent - start < quota) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_string();
            else if (sel < 75)
                send_plain_head();
            else if (sel < 85)
                send_item(ctl(cbor_enc_pkg::OP_RESTART));
            else if (sel < 92)
                send_item(pay(8'($urandom_range(0, 255))));
            else if (sel < 96)
                send_item(ctl(OP_UNUSED));
            else
                send_item(rand_fields());
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    initial begin
        int p;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every encoding length at its boundaries, reset buffer size
        send_item(head(MT_UINT, 64'd0, 1'b0));
        send_item(head(MT_UINT, 64'd23, 1'b0));
        send_item(head(MT_UINT, 64'd24, 1'b0));
        send_item(head(MT_UINT, 64'd255, 1'b0));
        send_item(head(MT_UINT, 64'd256, 1'b0));
        send_item(head(MT_UINT, 64'd65535, 1'b0));
        send_item(head(MT_UINT, 64'd65536, 1'b0));
        send_item(head(MT_UINT, 64'hFFFF_FFFF, 1'b0));
        send_item(head(MT_UINT, 64'h1_0000_0000, 1'b0));
        send_item(head(MT_UINT, '1, 1'b0));
        // Negative integers: all ones encodes as zero, zero as all ones
        send_item(head(cbor_enc_pkg::MT_NEG_INT, '1, 1'b0));
        send_item(head(cbor_enc_pkg::MT_NEG_INT, 64'd0, 1'b0));
        // Short string, then one byte past its announced length
        send_item(head(cbor_enc_pkg::MT_BYTES, 64'd2, 1'b0));
        send_item(pay(8'h00));
        send_item(pay(8'hFF));
        send_item(pay(8'h5A));
        // Head while payload is pending replaces the count
        send_item(head(cbor_enc_pkg::MT_TEXT, 64'd5, 1'b0));
        send_item(pay(8'hA5));
        send_item(head(MT_MAP, 64'd1, 1'b0));
        send_item(pay(8'h33));
        send_item(head(cbor_enc_pkg::MT_TEXT, {$urandom, $urandom}, 1'b1));
        send_item(head(MT_SIMPLE, 64'd20, 1'b0));
        send_item(head(cbor_enc_pkg::MT_BYTES, 64'h100_0000_0000, 1'b0));
        send_item(ctl(OP_UNUSED));
        send_item(ctl(cbor_enc_pkg::OP_RESTART));
        send_item(head(MT_TAG, 64'd1000, 1'b0));
        send_item(head(MT_ARRAY, 64'd3, 1'b0));

        // Lower the size below the write position: no space left at all.
        // After a restart one head byte fits exactly, the next one does not.
        wait_drained();
        write_size(17'd1);
        send_item(head(MT_UINT, 64'd0, 1'b0));
        send_item(ctl(cbor_enc_pkg::OP_RESTART));
        send_item(head(MT_UINT, 64'd7, 1'b0));
        send_item(head(MT_UINT, 64'd7, 1'b0));

        // Random phases, one buffer size each, starting from an empty buffer
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_size(phase_size(p));
            gaps_on = (p % 3 != 1);
            send_item(ctl(cbor_enc_pkg::OP_RESTART));
            run_random(RANDOM_ITEMS / NUM_PHASES);
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d input beats over %0d buffer sizes; %0d output beats checked",
                 items_sent, size_writes + 1, beats_checked);
        $display("with %0d overruns and %0d dropped payload bytes", overrun_count, drop_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/cbor_enc_pkg.sv
rtl/cbor_enc_front.sv
rtl/cbor_enc_queue.sv
rtl/cbor_enc_back.sv
rtl/cbor_item_head_encoder.sv
bench/cbor_item_head_checker.sv
bench/tb_top.sv
